// ----- src/dfsc_pkg.sv -----
package dfsc_pkg;

	// Framing and character codes
	localparam logic [7:0] START_BYTE = 8'h7B;
	localparam logic [7:0] END_BYTE   = 8'h7D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Default build parameters
	localparam int MAX_FRAME     = 32;
	localparam int COS_FRAC_BITS = 16;

	// Cosine table: entries sized for the widest fraction supported
	localparam int COS_FRAC_MAX = 24;
	localparam int COS_W        = COS_FRAC_MAX + 1;
	localparam int ANGLE_MAX    = 90;
	localparam int HALF_TURN    = 180;
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam int TAYLOR_TERMS = 10;

	// Front/back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Config register indexes
	typedef enum logic [1:0] {
		REG_SAFETY   = 2'd0,
		REG_TRACKING = 2'd1,
		REG_GAIN     = 2'd2,
		REG_SCANNING = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] safety;
		logic [15:0] tracking;
		logic [7:0]  gain;
		logic        scanning;
	} cfg_t;

	// Speed rule chosen at the end of a frame
	typedef enum logic [1:0] {
		RULE_ZERO = 2'd0,
		RULE_ADD  = 2'd1,
		RULE_HOLD = 2'd2
	} rule_t;

	// One speed job handed from front to back
	typedef struct packed {
		rule_t              rule;
		logic [31:0]        addend;
		logic [31:0]        distance;
		logic [COS_W-1:0]   cosq;
	} job_t;

	typedef logic [COS_W-1:0] cos_tab_t [0:ANGLE_MAX];

	// Restoring unsigned division for table construction at elaboration
	function automatic longint unsigned const_udiv(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem  = rem - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// |cos| per whole degree 0..90, Taylor series in Q30, rounded to Q(frac).
	// Evaluated at elaboration only.
	function automatic cos_tab_t build_cos_tab(input int frac);
		cos_tab_t          t;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint unsigned   dv;
		longint            sum;
		longint unsigned   r;
		for (int a = 0; a <= ANGLE_MAX; a++) begin
			x    = const_udiv(longint'(a) * PI_Q30, 64'(HALF_TURN));
			x2   = (x * x) >> 30;
			term = ONE_Q30;
			sum  = longint'(ONE_Q30);
			for (int k = 1; k <= TAYLOR_TERMS; k++) begin
				dv   = longint'((2 * k - 1) * (2 * k));
				term = const_udiv((term * x2) >> 30, dv);
				if ((k & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > longint'(ONE_Q30)) begin
				sum = longint'(ONE_Q30);
			end
			r    = (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
			t[a] = COS_W'(r);
		end
		return t;
	endfunction

endpackage

// ----- src/dfsc_rx_if.sv -----
interface dfsc_rx_if;
	logic              valid;
	logic              ready;
	logic [7:0]        rx_byte;
	logic signed [8:0] deviation_deg;

	modport source (output valid, output rx_byte, output deviation_deg, input ready);
	modport sink (input valid, input rx_byte, input deviation_deg, output ready);
endinterface

// ----- src/dfsc_cmd_if.sv -----
interface dfsc_cmd_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] speed_value;
	logic [31:0] parsed_distance;

	modport source (output valid, output command, output speed_value,
		output parsed_distance, input ready);
	modport sink (input valid, input command, input speed_value,
		input parsed_distance, output ready);
endinterface

// ----- src/dfsc_cfg_if.sv -----
interface dfsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/dfsc_front.sv -----
module dfsc_front #(
	parameter int MaxFrame    = 32,
	parameter int CosFracBits = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	dfsc_rx_if.sink        rx,
	input  dfsc_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           push,
	output dfsc_pkg::job_t push_job
);
	import dfsc_pkg::*;

	localparam int LEN_W = $clog2(MaxFrame + 1);
	localparam cos_tab_t COS_TAB = build_cos_tab(CosFracBits);

	typedef enum logic [2:0] {
		PH_SKIP   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	logic             in_frame_q;
	phase_t           phase_q;
	logic [31:0]      accum_q;
	logic [LEN_W-1:0] len_q;
	logic [31:0]      last_dist_q;

	logic        take;
	logic [7:0]  c;
	logic        is_space;
	logic        is_digit;
	logic [35:0] acc_x10;
	logic [31:0] acc_sat;
	logic [31:0] delta;
	logic [39:0] gain_delta;
	logic [8:0]  mag;
	logic [8:0]  mag_mod;
	logic [6:0]  angle;

	assign rx.ready = !q_full;
	assign take     = rx.valid && rx.ready;
	assign c        = rx.rx_byte;

	// Character classes and saturating decimal accumulate
	assign is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
	assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	assign acc_x10  = 36'(accum_q) * 36'd10 + 36'(c[3:0]);
	assign acc_sat  = (|acc_x10[35:32]) ? '1 : acc_x10[31:0];

	// Speed increment is independent of the running speed
	assign delta      = accum_q - last_dist_q;
	assign gain_delta = 40'(cfg.gain) * 40'(delta);

	// Fold the angle into 0..90 and look up |cos|
	assign mag     = rx.deviation_deg[8] ? (~rx.deviation_deg + 9'd1)
		: rx.deviation_deg;
	assign mag_mod = (mag >= 9'(HALF_TURN)) ? mag - 9'(HALF_TURN) : mag;
	assign angle   = (mag_mod > 9'(ANGLE_MAX)) ? 7'(9'(HALF_TURN) - mag_mod)
		: mag_mod[6:0];

	// Job for the end of frame
	assign push = take && in_frame_q && (c == END_BYTE) && !cfg.scanning;

	always_comb begin
		push_job.addend   = gain_delta[31:0];
		push_job.distance = accum_q;
		push_job.cosq     = COS_TAB[angle];
		if (accum_q <= 32'(cfg.safety)) begin
			push_job.rule = RULE_ZERO;
		end else if (accum_q > 32'(cfg.tracking)) begin
			push_job.rule = RULE_ADD;
		end else begin
			push_job.rule = RULE_HOLD;
		end
	end

	// Frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			phase_q     <= PH_SKIP;
			accum_q     <= '0;
			len_q       <= '0;
			last_dist_q <= '0;
		end else if (take) begin
			if (!in_frame_q) begin
				if (c == START_BYTE) begin
					in_frame_q <= 1'b1;
					phase_q    <= PH_SKIP;
					accum_q    <= '0;
					len_q      <= '0;
				end
			end else if (c == END_BYTE) begin
				in_frame_q  <= 1'b0;
				last_dist_q <= accum_q;
				phase_q     <= PH_SKIP;
				accum_q     <= '0;
				len_q       <= '0;
			end else if (len_q < LEN_W'(MaxFrame)) begin
				len_q <= len_q + 1'b1;
				priority if (phase_q == PH_SKIP && is_space) begin
					// leading blank: nothing to do
				end else if (phase_q != PH_DONE && is_digit) begin
					accum_q <= acc_sat;
					phase_q <= PH_DIGITS;
				end else begin
					phase_q <= PH_DONE;
				end
			end
		end
	end

endmodule

// ----- src/dfsc_queue.sv -----
module dfsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dfsc_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output dfsc_pkg::job_t head
);
	import dfsc_pkg::*;

	job_t              mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/dfsc_back.sv -----
module dfsc_back #(
	parameter int CosFracBits = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  dfsc_pkg::job_t q_head,
	output logic           pop,
	dfsc_cmd_if.source     cmd
);
	import dfsc_pkg::*;

	localparam int PROD_W = 33 + CosFracBits;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SCALE = 2'b10
	} state_t;

	state_t                 state_q;
	logic [31:0]            speed_q;
	logic [31:0]            sum_s1;
	logic [CosFracBits:0]   cos_s1;
	logic [31:0]            dist_s1;
	logic                   out_valid_q;
	logic                   out_cmd_q;
	logic [31:0]            out_speed_q;
	logic [31:0]            out_dist_q;

	logic              out_free;
	logic              finish;
	logic [PROD_W-1:0] prod;
	logic [31:0]       scaled;

	assign out_free = !out_valid_q || cmd.ready;
	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign finish   = (state_q == ST_SCALE) && out_free;

	// Q-format cosine scaling of the updated speed
	assign prod   = PROD_W'(sum_s1) * PROD_W'(cos_s1);
	assign scaled = prod[CosFracBits +: 32];

	assign cmd.valid           = out_valid_q;
	assign cmd.command         = out_cmd_q;
	assign cmd.speed_value     = out_speed_q;
	assign cmd.parsed_distance = out_dist_q;

	// Speed rule stage
	always_ff @(posedge clk) begin
		if (pop) begin
			cos_s1  <= q_head.cosq[CosFracBits:0];
			dist_s1 <= q_head.distance;
			unique case (q_head.rule)
				RULE_ZERO: sum_s1 <= '0;
				RULE_ADD:  sum_s1 <= speed_q + q_head.addend;
				RULE_HOLD: sum_s1 <= speed_q;
				default:   sum_s1 <= speed_q;
			endcase
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (finish) begin
			out_cmd_q   <= (sum_s1 != '0);
			out_speed_q <= scaled;
			out_dist_q  <= dist_s1;
		end
	end

	// Sequencer, running speed and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			speed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
				speed_q     <= scaled;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/distance_follow_speed_controller_top.sv -----
// Distance-follow speed controller. Takes one serial byte (with the current
// deviation angle) per transaction and may accept a byte every clock cycle
// while the queue is not full. Frames run from 0x7B to 0x7D; at the end byte
// the parsed distance drives the speed rule and, unless scanning mode is set,
// one STOP or SPEED transaction comes out carrying the distance. The front
// end parses bytes, picks the rule and looks up |cos| combinationally as the
// end byte is taken; a two-entry queue feeds the back end, which latches the
// speed rule result in ST_IDLE, then does the Q-format cosine multiply that
// feeds back into the running speed in ST_SCALE, and pops the next frame only
// once ST_SCALE is left. From the end byte a job passes the queue, the speed
// rule register and the output register. Configuration writes are taken at
// any time and must only be issued while the block is idle.
module distance_follow_speed_controller_top #(
	parameter int MaxFrame    = dfsc_pkg::MAX_FRAME,
	parameter int CosFracBits = dfsc_pkg::COS_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	dfsc_rx_if.sink     rx,
	dfsc_cmd_if.source  cmd,
	dfsc_cfg_if.sink    cfg
);
	import dfsc_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic push;
	job_t push_job;
	job_t q_head;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.safety   <= 16'd15;
			cfg_q.tracking <= 16'd25;
			cfg_q.gain     <= 8'd5;
			cfg_q.scanning <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_SAFETY:   cfg_q.safety   <= cfg.data;
				REG_TRACKING: cfg_q.tracking <= cfg.data;
				REG_GAIN:     cfg_q.gain     <= cfg.data[7:0];
				REG_SCANNING: cfg_q.scanning <= cfg.data[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	dfsc_front #(
		.MaxFrame    (MaxFrame),
		.CosFracBits (CosFracBits)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	dfsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	dfsc_back #(
		.CosFracBits (CosFracBits)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (q_pop),
		.cmd     (cmd)
	);

endmodule
